>>> hw/rtl/bfc_pkg.sv
// Shared types and constants for the back-face cull and depth key block.
package bfc_pkg;

    localparam int IDX_W       = 9;
    localparam int RECIP_SHIFT = 21;

    // (2^21 + 1) / 3: exact floor(x / 3) for any x below 2^21
    localparam logic [19:0] RECIP3 = 20'd699051;

    typedef enum logic [1:0] {
        REQ_VERTEX,
        REQ_POLYGON,
        REQ_START,
        REQ_UNUSED
    } t_req;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic done;
        logic back;
    } t_dot_res;

    typedef struct packed {
        logic               done;
        logic signed [31:0] avg;
    } t_div_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_FINISH
    } t_state;

endpackage

>>> hw/rtl/bfc_vertex_mem.sv
// Vertex memory: one write port, one read port, registered read data.
module bfc_vertex_mem #(
    parameter int SLOTS = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [bfc_pkg::IDX_W-1:0]    i_wr_idx,
    input  bfc_pkg::t_vec                i_wr_data,
    input  logic                         i_rd_en,
    input  logic [bfc_pkg::IDX_W-1:0]    i_rd_idx,
    output bfc_pkg::t_vec                o_rd_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int EW = bfc_pkg::IDX_W + AW;

    bfc_pkg::t_vec r_mem [SLOTS];
    bfc_pkg::t_vec r_rd_data;
    logic          r_rd_ok;

    logic [EW-1:0] w_wr_ext;
    logic [EW-1:0] w_rd_ext;
    logic          w_wr_ok;
    logic          w_rd_ok;

    assign w_wr_ext = EW'(i_wr_idx);
    assign w_rd_ext = EW'(i_rd_idx);
    assign w_wr_ok  = w_wr_ext < EW'(SLOTS);
    assign w_rd_ok  = w_rd_ext < EW'(SLOTS);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wr_ok) begin
            r_mem[w_wr_ext[AW-1:0]] <= i_wr_data;
        end
        if (i_rd_en && w_rd_ok) begin
            r_rd_data <= r_mem[w_rd_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_ok <= w_rd_ok;
        end
    end

    // slots beyond the store read as zero
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

>>> hw/rtl/bfc_dot_unit.sv
// Facing test: exact dot of (tip - v) with -v on one shared multiplier.
module bfc_dot_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bfc_pkg::t_vec       i_tip,
    input  bfc_pkg::t_vec       i_vert,
    output bfc_pkg::t_dot_res   o_res
);

    logic signed [32:0] r_dx, r_dy, r_dz;
    logic signed [32:0] r_nx, r_ny, r_nz;
    logic signed [65:0] r_prod;
    logic signed [67:0] r_acc;
    logic [1:0]         r_k;
    logic               r_mul_on;
    logic               r_prod_v;
    logic               r_prod_last;
    logic               r_done;

    logic signed [32:0] w_a;
    logic signed [32:0] w_b;
    logic signed [65:0] w_prod;

    always_comb begin
        case (r_k)
            2'd0: begin
                w_a = r_dx;
                w_b = r_nx;
            end
            2'd1: begin
                w_a = r_dy;
                w_b = r_ny;
            end
            default: begin
                w_a = r_dz;
                w_b = r_nz;
            end
        endcase
    end

    assign w_prod = 66'(w_a) * 66'(w_b);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx  <= 33'($signed(i_tip.x)) - 33'($signed(i_vert.x));
            r_dy  <= 33'($signed(i_tip.y)) - 33'($signed(i_vert.y));
            r_dz  <= 33'($signed(i_tip.z)) - 33'($signed(i_vert.z));
            r_nx  <= 33'sd0 - 33'($signed(i_vert.x));
            r_ny  <= 33'sd0 - 33'($signed(i_vert.y));
            r_nz  <= 33'sd0 - 33'($signed(i_vert.z));
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + 68'(r_prod);
        end
        if (r_mul_on) begin
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_on    <= 1'b0;
            r_k         <= 2'd0;
            r_prod_v    <= 1'b0;
            r_prod_last <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (i_start) begin
                r_mul_on <= 1'b1;
                r_k      <= 2'd0;
            end else if (r_mul_on) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_mul_on <= 1'b0;
                end
            end
            r_prod_v    <= r_mul_on;
            r_prod_last <= r_mul_on && (r_k == 2'd2);
            r_done      <= r_prod_v && r_prod_last;
        end
    end

    assign o_res.done = r_done;
    assign o_res.back = r_acc[67];

endmodule

>>> hw/rtl/bfc_depth_div.sv
// Mean depth: signed sum over three or four corners, truncated toward zero.
module bfc_depth_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [33:0]  i_sum,
    input  logic                i_quad,
    output bfc_pkg::t_div_res   o_res
);

    logic [33:0] r_mag;
    logic [16:0] r_mh;
    logic [15:0] r_qh;
    logic        r_neg;
    logic        r_quad;
    logic [32:0] r_q;
    logic        r_neg2;
    logic        r_v1;
    logic        r_v2;

    logic        w_neg;
    logic [33:0] w_mag;
    logic [36:0] w_qh_prod;
    logic [16:0] w_rh;
    logic [18:0] w_x2;
    logic [38:0] w_ql_prod;
    logic [32:0] w_q;

    assign w_neg     = i_sum[33];
    assign w_mag     = w_neg ? (34'd0 - i_sum) : i_sum;
    assign w_qh_prod = 37'(w_mag[33:17]) * 37'(bfc_pkg::RECIP3);

    // high half: q = mh / 3, remainder carried into the low half
    assign w_rh      = r_mh - (17'({r_qh, 1'b0}) + 17'(r_qh));
    assign w_x2      = {w_rh[1:0], r_mag[16:0]};
    assign w_ql_prod = 39'(w_x2) * 39'(bfc_pkg::RECIP3);
    assign w_q       = r_quad ? 33'(r_mag[33:2])
                              : {r_qh, w_ql_prod[37:bfc_pkg::RECIP_SHIFT]};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag  <= w_mag;
            r_mh   <= w_mag[33:17];
            r_qh   <= w_qh_prod[36:bfc_pkg::RECIP_SHIFT];
            r_neg  <= w_neg;
            r_quad <= i_quad;
        end
        if (r_v1) begin
            r_q    <= w_q;
            r_neg2 <= r_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign o_res.done = r_v2;
    assign o_res.avg  = r_neg2 ? 32'(33'd0 - r_q) : 32'(r_q);

endmodule

>>> hw/rtl/backface_cull_depth_key.sv
// Back-face cull with average depth key: top level, sequencer and output word.
//
// Vertex-write and start words are accepted without a stall. A polygon word
// holds the input from acceptance until the next word can be taken: its
// corners are read one per cycle through the single read port of the vertex
// memory, the facing dot product runs on one shared multiplier alongside
// those reads, and the depth sum then goes through a two-stage divide by the
// corner count. A finished result waits in the output register, so the next
// word is accepted while it is stalled.
// The vertex memory is not cleared at reset; reading a slot that was never
// written gives an unspecified result.
module backface_cull_depth_key #(
    parameter int VERTEX_SLOTS = 512,
    parameter int MAX_CORNERS  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_req_type,
    input  logic [8:0]          i_vertex_index,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    input  logic [2:0]          i_corner_count,
    input  logic [8:0]          i_corner_a,
    input  logic [8:0]          i_corner_b,
    input  logic [8:0]          i_corner_c,
    input  logic [8:0]          i_corner_d,
    input  logic [11:0]         i_polygon_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [11:0]         o_visible_polygon,
    output logic signed [31:0]  o_depth_average,
    output logic [11:0]         o_visible_slot
);

    localparam logic [2:0] MIN_CNT  = 3'd3;
    localparam logic [2:0] QUAD_CNT = 3'd4;
    localparam logic [2:0] MAX_CNT  = 3'(MAX_CORNERS);
    localparam logic [2:0] STEP_A   = 3'd1;
    localparam logic [2:0] STEP_C   = 3'd2;

    bfc_pkg::t_state r_state, n_state;

    bfc_pkg::t_vec       r_tip;
    logic [8:0]          r_corner_a, r_corner_c, r_corner_d;
    logic [2:0]          r_count;
    logic [11:0]         r_id;
    logic [2:0]          r_step;
    logic                r_rd_v;
    logic                r_rd_first;
    logic signed [33:0]  r_sum;
    logic                r_div_go;
    logic                r_dot_ok;
    logic                r_div_ok;
    logic                r_out_valid;
    logic [11:0]         r_out_poly;
    logic signed [31:0]  r_out_depth;
    logic [11:0]         r_out_slot;
    logic [11:0]         r_vis_count;

    logic                w_acc;
    logic                w_acc_wr;
    logic                w_acc_poly;
    logic                w_acc_start;
    logic [2:0]          w_cnt;
    logic                w_issue;
    logic                w_fetch_end;
    logic                w_ready;
    logic                w_out_free;
    logic                w_load;
    logic                w_drop;
    logic                w_rd_en;
    logic [8:0]          w_rd_idx;
    bfc_pkg::t_vec       w_wr_data;
    bfc_pkg::t_vec       w_rd_data;
    bfc_pkg::t_dot_res   w_dot;
    bfc_pkg::t_div_res   w_div;

    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_acc_wr    = w_acc && (i_req_type == bfc_pkg::REQ_VERTEX);
    assign w_acc_poly  = w_acc && (i_req_type == bfc_pkg::REQ_POLYGON);
    assign w_acc_start = w_acc && (i_req_type == bfc_pkg::REQ_START);

    always_comb begin
        if (i_corner_count < MIN_CNT) begin
            w_cnt = MIN_CNT;
        end else if (i_corner_count > MAX_CNT) begin
            w_cnt = MAX_CNT;
        end else begin
            w_cnt = i_corner_count;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfc_pkg::S_IDLE: begin
                if (w_acc_poly) begin
                    n_state = bfc_pkg::S_FETCH;
                end
            end
            bfc_pkg::S_FETCH: begin
                if (w_fetch_end) begin
                    n_state = bfc_pkg::S_FINISH;
                end
            end
            bfc_pkg::S_FINISH: begin
                if (w_load || w_drop) begin
                    n_state = bfc_pkg::S_IDLE;
                end
            end
            default: n_state = bfc_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_issue     = 1'b0;
        w_fetch_end = 1'b0;
        w_ready     = 1'b0;
        unique case (r_state)
            bfc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            bfc_pkg::S_FETCH: begin
                w_issue     = r_step < r_count;
                w_fetch_end = r_rd_v && !(r_step < r_count);
            end
            bfc_pkg::S_FINISH: begin
                w_ready = (r_dot_ok || w_dot.done) && (r_div_ok || w_div.done);
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_load = w_ready && !w_dot.back && w_out_free;
    assign w_drop = w_ready && w_dot.back;

    // reference corner first, then the rest in list order
    always_comb begin
        if (w_acc_poly) begin
            w_rd_idx = i_corner_b;
        end else begin
            case (r_step)
                STEP_A:  w_rd_idx = r_corner_a;
                STEP_C:  w_rd_idx = r_corner_c;
                default: w_rd_idx = r_corner_d;
            endcase
        end
    end

    assign w_rd_en   = w_acc_poly || w_issue;
    assign w_wr_data = '{x: i_coord_x, y: i_coord_y, z: i_coord_z};

    bfc_vertex_mem #(
        .SLOTS(VERTEX_SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_acc_wr),
        .i_wr_idx  (i_vertex_index),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_idx  (w_rd_idx),
        .o_rd_data (w_rd_data)
    );

    bfc_dot_unit u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rd_v && r_rd_first),
        .i_tip   (r_tip),
        .i_vert  (w_rd_data),
        .o_res   (w_dot)
    );

    bfc_depth_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_sum   (r_sum),
        .i_quad  (r_count == QUAD_CNT),
        .o_res   (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfc_pkg::S_IDLE;
            r_step      <= 3'd0;
            r_rd_v      <= 1'b0;
            r_rd_first  <= 1'b0;
            r_div_go    <= 1'b0;
            r_dot_ok    <= 1'b0;
            r_div_ok    <= 1'b0;
            r_out_valid <= 1'b0;
            r_vis_count <= 12'd0;
        end else begin
            r_state    <= n_state;
            r_rd_v     <= w_rd_en;
            r_rd_first <= w_acc_poly;
            r_div_go   <= w_fetch_end;
            if (w_acc_poly) begin
                r_step <= STEP_A;
            end else if (w_issue) begin
                r_step <= r_step + 3'd1;
            end
            if (w_acc_poly) begin
                r_dot_ok <= 1'b0;
            end else if (w_dot.done) begin
                r_dot_ok <= 1'b1;
            end
            if (w_acc_poly) begin
                r_div_ok <= 1'b0;
            end else if (w_div.done) begin
                r_div_ok <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_acc_start) begin
                r_vis_count <= 12'd0;
            end else if (w_load) begin
                r_vis_count <= r_vis_count + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_poly) begin
            r_tip      <= w_wr_data;
            r_corner_a <= i_corner_a;
            r_corner_c <= i_corner_c;
            r_corner_d <= i_corner_d;
            r_count    <= w_cnt;
            r_id       <= i_polygon_id;
            r_sum      <= '0;
        end else if (r_rd_v) begin
            r_sum <= r_sum + 34'($signed(w_rd_data.z));
        end
        if (w_load) begin
            r_out_poly  <= r_id;
            r_out_depth <= w_div.avg;
            r_out_slot  <= r_vis_count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_visible_polygon = r_out_poly;
    assign o_depth_average   = r_out_depth;
    assign o_visible_slot    = r_out_slot;

`ifndef SYNTHESIS
    a_poly_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_poly |=> o_in_stall)
        else $error("polygon word accepted without holding the input");

    a_all_corners_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfc_pkg::S_FINISH) |-> (r_step == r_count))
        else $error("finish reached before every corner was read");

    a_no_read_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfc_pkg::S_IDLE) |-> (!r_rd_v && !r_div_go))
        else $error("read data or divide launch pending while idle");

    a_slot_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_vis_count == $past(r_vis_count) + 12'd1)
            && (o_visible_slot == $past(r_vis_count)))
        else $error("visible slot and count out of step");
`endif

endmodule
